@@ rtl/core/gws_pkg.sv @@
// gws_pkg: shared types, constants and the 5x7 font table of the glyph window streamer
// used by the interfaces, the front, queue and back modules and the top level
package gws_pkg;

  // default glyph cell size
  localparam int unsigned GlyphWidthDef  = 5;
  localparam int unsigned GlyphHeightDef = 7;

  // font table geometry
  localparam int unsigned RomCols   = 5;
  localparam logic [6:0]  FirstCode = 7'd32;
  localparam logic [6:0]  LastCode  = 7'd126;

  // display controller commands
  localparam logic [15:0] CmdColWin = 16'h002A;
  localparam logic [15:0] CmdRowWin = 16'h002B;
  localparam logic [15:0] CmdMemWr  = 16'h002C;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegForeColor = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBackColor = 2'd1;

  localparam logic [15:0] ForeColorRst = 16'hFFFF;
  localparam logic [15:0] BackColorRst = 16'h0000;

  // queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // one glyph: column bytes, column 0 first, bit 0 is the top row
  typedef logic [0:RomCols-1][7:0] glyph_t;

  // one classified character, ready for the back end
  typedef struct packed {
    logic [15:0] x_start;
    logic [15:0] x_end;
    logic [15:0] y_start;
    logic [15:0] y_end;
    logic        bad;
    glyph_t      glyph;
  } char_desc_t;

  // queue fill status
  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [QueueCntW-1:0] count;
  } queue_status_t;

  // pixel colors
  typedef struct packed {
    logic [15:0] fore;
    logic [15:0] back;
  } colors_t;

  // back end sequencer phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEAD,
    PH_PIXEL
  } phase_e;

  // font lookup, codes outside the printable range return a blank glyph
  function automatic glyph_t font_glyph(logic [6:0] code);
    glyph_t g;
    g = '0;
    case (code)
      7'd32:  g = 40'h00_00_00_00_00;
      7'd33:  g = 40'h00_00_5F_00_00;
      7'd34:  g = 40'h00_07_00_07_00;
      7'd35:  g = 40'h14_7F_14_7F_14;
      7'd36:  g = 40'h24_2A_7F_2A_12;
      7'd37:  g = 40'h23_13_08_64_62;
      7'd38:  g = 40'h36_49_55_22_50;
      7'd39:  g = 40'h00_00_03_00_00;
      7'd40:  g = 40'h00_1C_22_41_00;
      7'd41:  g = 40'h00_41_22_1C_00;
      7'd42:  g = 40'h14_08_3E_08_14;
      7'd43:  g = 40'h08_08_3E_08_08;
      7'd44:  g = 40'h00_50_30_00_00;
      7'd45:  g = 40'h08_08_08_08_08;
      7'd46:  g = 40'h00_60_60_00_00;
      7'd47:  g = 40'h20_10_08_04_02;
      7'd48:  g = 40'h3E_51_49_45_3E;
      7'd49:  g = 40'h00_42_7F_40_00;
      7'd50:  g = 40'h62_51_49_49_46;
      7'd51:  g = 40'h22_41_49_49_36;
      7'd52:  g = 40'h18_14_12_7F_10;
      7'd53:  g = 40'h27_45_45_45_39;
      7'd54:  g = 40'h3C_4A_49_49_30;
      7'd55:  g = 40'h01_71_09_05_03;
      7'd56:  g = 40'h36_49_49_49_36;
      7'd57:  g = 40'h06_49_49_29_1E;
      7'd58:  g = 40'h00_36_36_00_00;
      7'd59:  g = 40'h00_56_36_00_00;
      7'd60:  g = 40'h08_14_22_41_00;
      7'd61:  g = 40'h14_14_14_14_14;
      7'd62:  g = 40'h00_41_22_14_08;
      7'd63:  g = 40'h02_01_51_09_06;
      7'd64:  g = 40'h32_49_79_41_3E;
      7'd65:  g = 40'h7C_12_11_12_7C;
      7'd66:  g = 40'h41_7F_49_49_36;
      7'd67:  g = 40'h3E_41_41_41_22;
      7'd68:  g = 40'h41_7F_41_41_3E;
      7'd69:  g = 40'h7F_49_49_49_41;
      7'd70:  g = 40'h7F_09_09_09_01;
      7'd71:  g = 40'h3E_41_41_49_7A;
      7'd72:  g = 40'h7F_08_08_08_7F;
      7'd73:  g = 40'h00_41_7F_41_00;
      7'd74:  g = 40'h20_40_41_3F_01;
      7'd75:  g = 40'h7F_08_14_22_41;
      7'd76:  g = 40'h7F_40_40_40_40;
      7'd77:  g = 40'h7F_02_0C_02_7F;
      7'd78:  g = 40'h7F_04_08_10_7F;
      7'd79:  g = 40'h3E_41_41_41_3E;
      7'd80:  g = 40'h7F_09_09_09_06;
      7'd81:  g = 40'h3E_41_51_21_5E;
      7'd82:  g = 40'h7F_09_19_29_46;
      7'd83:  g = 40'h26_49_49_49_32;
      7'd84:  g = 40'h01_01_7F_01_01;
      7'd85:  g = 40'h3F_40_40_40_3F;
      7'd86:  g = 40'h1F_20_40_20_1F;
      7'd87:  g = 40'h3F_40_38_40_3F;
      7'd88:  g = 40'h63_14_08_14_63;
      7'd89:  g = 40'h07_08_70_08_07;
      7'd90:  g = 40'h61_51_49_45_43;
      7'd91:  g = 40'h00_7F_41_41_00;
      7'd92:  g = 40'h02_04_08_10_20;
      7'd93:  g = 40'h00_41_41_7F_00;
      7'd94:  g = 40'h04_02_01_02_04;
      7'd95:  g = 40'h40_40_40_40_40;
      7'd96:  g = 40'h00_01_02_04_00;
      7'd97:  g = 40'h20_54_54_54_78;
      7'd98:  g = 40'h7F_48_44_44_38;
      7'd99:  g = 40'h38_44_44_44_20;
      7'd100: g = 40'h38_44_44_48_7F;
      7'd101: g = 40'h38_54_54_54_18;
      7'd102: g = 40'h08_7E_09_01_02;
      7'd103: g = 40'h08_54_54_54_3C;
      7'd104: g = 40'h7F_08_04_04_78;
      7'd105: g = 40'h00_48_7D_40_00;
      7'd106: g = 40'h20_40_44_3D_00;
      7'd107: g = 40'h7F_10_28_44_00;
      7'd108: g = 40'h00_41_7F_40_00;
      7'd109: g = 40'h7C_04_78_04_78;
      7'd110: g = 40'h7C_08_04_04_78;
      7'd111: g = 40'h38_44_44_44_38;
      7'd112: g = 40'h7C_14_14_14_08;
      7'd113: g = 40'h08_14_14_18_7C;
      7'd114: g = 40'h7C_08_04_04_08;
      7'd115: g = 40'h48_54_54_54_20;
      7'd116: g = 40'h04_3F_44_40_20;
      7'd117: g = 40'h3C_40_40_20_7C;
      7'd118: g = 40'h1C_20_40_20_1C;
      7'd119: g = 40'h3C_40_30_40_3C;
      7'd120: g = 40'h44_28_10_28_44;
      7'd121: g = 40'h0C_50_50_50_3C;
      7'd122: g = 40'h44_64_54_4C_44;
      7'd123: g = 40'h00_08_36_41_00;
      7'd124: g = 40'h00_00_7F_00_00;
      7'd125: g = 40'h00_41_36_08_00;
      7'd126: g = 40'h10_08_08_10_08;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

@@ rtl/core/gws_if.sv @@
// gws_if: valid/ready channel interfaces for characters, output words and config writes
// depends on gws_pkg for the config index width
interface gws_char_if;
  logic        valid;
  logic        ready;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [6:0]  char_code;

  modport source (output valid, output pos_x, output pos_y, output char_code, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input char_code, output ready);
endinterface

interface gws_word_if;
  logic        valid;
  logic        ready;
  logic        is_data;
  logic [15:0] out_word;
  logic        bad_code;
  logic        last;

  modport source (output valid, output is_data, output out_word, output bad_code,
                  output last, input ready);
  modport sink   (input valid, input is_data, input out_word, input bad_code,
                  input last, output ready);
endinterface

interface gws_cfg_if;
  import gws_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [15:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/gws_front.sv @@
// gws_front: accepts characters, classifies the code and builds the window descriptor
// depends on gws_pkg (font table, descriptor types) and gws_char_if
module gws_front #(
  parameter int unsigned GLYPH_WIDTH  = gws_pkg::GlyphWidthDef,
  parameter int unsigned GLYPH_HEIGHT = gws_pkg::GlyphHeightDef
) (
  gws_char_if.sink                  char_i,
  input  gws_pkg::queue_status_t    q_status_i,
  output logic                      push_o,
  output gws_pkg::char_desc_t       push_desc_o
);
  import gws_pkg::*;

  logic bad;

  // stall only when the queue has no room
  assign char_i.ready = !q_status_i.full;
  assign push_o       = char_i.valid && !q_status_i.full;

  // codes outside the font draw blank
  assign bad = (char_i.char_code < FirstCode) || (char_i.char_code > LastCode);

  // window corners wrap at 16 bits
  always_comb begin
    push_desc_o.x_start = char_i.pos_x;
    push_desc_o.x_end   = char_i.pos_x + 16'(GLYPH_WIDTH - 1);
    push_desc_o.y_start = char_i.pos_y;
    push_desc_o.y_end   = char_i.pos_y + 16'(GLYPH_HEIGHT - 1);
    push_desc_o.bad     = bad;
    push_desc_o.glyph   = font_glyph(char_i.char_code);
  end

endmodule

@@ rtl/core/gws_queue.sv @@
// gws_queue: short descriptor queue between front and back
// depends on gws_pkg for the descriptor type and depth
module gws_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  gws_pkg::char_desc_t    push_desc_i,
  input  logic                   pop_i,
  output gws_pkg::char_desc_t    head_desc_o,
  output gws_pkg::queue_status_t status_o
);
  import gws_pkg::*;

  char_desc_t           entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_desc_i;
    end
  end

  assign head_desc_o    = entry_q[rd_ptr_q];
  assign status_o.count = count_q;
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == QueueCntW'(QueueDepth));

endmodule

@@ rtl/core/gws_back.sv @@
// gws_back: sequencer that turns one descriptor into window commands and pixel words
// depends on gws_pkg (descriptor, colors, phase enum) and gws_word_if
module gws_back #(
  parameter int unsigned GLYPH_WIDTH  = gws_pkg::GlyphWidthDef,
  parameter int unsigned GLYPH_HEIGHT = gws_pkg::GlyphHeightDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gws_pkg::colors_t       colors_i,
  input  gws_pkg::char_desc_t    head_desc_i,
  input  gws_pkg::queue_status_t q_status_i,
  output logic                   pop_o,
  gws_word_if.source             word_o
);
  import gws_pkg::*;

  localparam int unsigned ColW = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
  localparam int unsigned RowW = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;

  // header word positions
  localparam logic [3:0] StepColCmd = 4'd0;
  localparam logic [3:0] StepXsHi   = 4'd1;
  localparam logic [3:0] StepXsLo   = 4'd2;
  localparam logic [3:0] StepXeHi   = 4'd3;
  localparam logic [3:0] StepXeLo   = 4'd4;
  localparam logic [3:0] StepRowCmd = 4'd5;
  localparam logic [3:0] StepYsHi   = 4'd6;
  localparam logic [3:0] StepYsLo   = 4'd7;
  localparam logic [3:0] StepYeHi   = 4'd8;
  localparam logic [3:0] StepYeLo   = 4'd9;
  localparam logic [3:0] StepMemCmd = 4'd10;

  phase_e          phase_q, phase_d;
  logic [3:0]      step_q, step_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  char_desc_t      cur_q, cur_d;

  logic            ov_q, ov_d;
  logic            is_data_q, is_data_d;
  logic [15:0]     word_q, word_d;
  logic            bad_q, bad_d;
  logic            last_q, last_d;

  logic            load;
  logic            col_end, row_end;
  logic [2:0]      col_ext, row_ext;
  logic [7:0]      col_byte;
  logic            pix_bit;
  logic [15:0]     head_word;
  logic            head_cmd;

  // output register advances when empty or being taken
  assign load    = !ov_q || word_o.ready;
  assign col_end = (col_q == ColW'(GLYPH_WIDTH - 1));
  assign row_end = (row_q == RowW'(GLYPH_HEIGHT - 1));

  // glyph bit of the current pixel, columns past the font read blank
  assign col_ext  = 3'(col_q);
  assign row_ext  = 3'(row_q);
  assign col_byte = (col_ext < 3'(RomCols)) ? cur_q.glyph[col_ext] : 8'h00;
  assign pix_bit  = col_byte[row_ext];

  // header word select
  always_comb begin
    head_cmd  = 1'b0;
    head_word = 16'h0000;
    case (step_q)
      StepColCmd: begin
        head_cmd  = 1'b1;
        head_word = CmdColWin;
      end
      StepXsHi:   head_word = {8'h00, cur_q.x_start[15:8]};
      StepXsLo:   head_word = {8'h00, cur_q.x_start[7:0]};
      StepXeHi:   head_word = {8'h00, cur_q.x_end[15:8]};
      StepXeLo:   head_word = {8'h00, cur_q.x_end[7:0]};
      StepRowCmd: begin
        head_cmd  = 1'b1;
        head_word = CmdRowWin;
      end
      StepYsHi:   head_word = {8'h00, cur_q.y_start[15:8]};
      StepYsLo:   head_word = {8'h00, cur_q.y_start[7:0]};
      StepYeHi:   head_word = {8'h00, cur_q.y_end[15:8]};
      StepYeLo:   head_word = {8'h00, cur_q.y_end[7:0]};
      StepMemCmd: begin
        head_cmd  = 1'b1;
        head_word = CmdMemWr;
      end
      default: begin
        head_cmd  = 1'b1;
        head_word = CmdMemWr;
      end
    endcase
  end

  // sequencer next state and output word
  always_comb begin
    phase_d   = phase_q;
    step_d    = step_q;
    col_d     = col_q;
    row_d     = row_q;
    cur_d     = cur_q;
    ov_d      = ov_q;
    is_data_d = is_data_q;
    word_d    = word_q;
    bad_d     = bad_q;
    last_d    = last_q;
    pop_o     = 1'b0;
    if (load) begin
      ov_d = 1'b0;
      case (phase_q)
        PH_IDLE: begin
          if (!q_status_i.empty) begin
            pop_o   = 1'b1;
            cur_d   = head_desc_i;
            phase_d = PH_HEAD;
            step_d  = StepColCmd;
          end
        end
        PH_HEAD: begin
          ov_d      = 1'b1;
          is_data_d = !head_cmd;
          word_d    = head_word;
          bad_d     = cur_q.bad;
          last_d    = 1'b0;
          step_d    = step_q + 1'b1;
          if (step_q == StepMemCmd) begin
            phase_d = PH_PIXEL;
            col_d   = '0;
            row_d   = '0;
          end
        end
        PH_PIXEL: begin
          ov_d      = 1'b1;
          is_data_d = 1'b1;
          word_d    = pix_bit ? colors_i.fore : colors_i.back;
          bad_d     = cur_q.bad;
          last_d    = col_end && row_end;
          if (col_end) begin
            col_d = '0;
            row_d = row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
          // last pixel: pick up the next character without a gap
          if (col_end && row_end) begin
            if (!q_status_i.empty) begin
              pop_o   = 1'b1;
              cur_d   = head_desc_i;
              phase_d = PH_HEAD;
              step_d  = StepColCmd;
            end else begin
              phase_d = PH_IDLE;
            end
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      step_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
      col_q   <= col_d;
      row_q   <= row_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    is_data_q <= is_data_d;
    word_q    <= word_d;
    bad_q     <= bad_d;
    last_q    <= last_d;
  end

  assign word_o.valid    = ov_q;
  assign word_o.is_data  = is_data_q;
  assign word_o.out_word = word_q;
  assign word_o.bad_code = bad_q;
  assign word_o.last     = last_q;

endmodule

@@ rtl/core/glyph_window_streamer_core.sv @@
// glyph_window_streamer_core: top level, config registers and front/queue/back wiring
// depends on gws_pkg, gws_if, gws_front, gws_queue and gws_back
//
//   port     dir   role
//   char_i   sink  character with x, y and code
//   word_o   src   command bytes, coordinate bytes and pixel words
//   cfg_i    sink  color register writes (0 fore, 1 back)
//
// each character gives 11 + GLYPH_WIDTH*GLYPH_HEIGHT words, 46 at 5x7, one word a cycle
// from the back sequencer while the receiver is ready and characters are queued
// from idle a character passes the queue, the sequencer and the output register
// a two-entry queue takes up to two characters while the output is stalled
// reset clears queue, sequencer and output valid; colors reset to white on black
module glyph_window_streamer_core #(
  parameter int unsigned GLYPH_WIDTH  = gws_pkg::GlyphWidthDef,
  parameter int unsigned GLYPH_HEIGHT = gws_pkg::GlyphHeightDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gws_char_if.sink   char_i,
  gws_word_if.source word_o,
  gws_cfg_if.sink    cfg_i
);
  import gws_pkg::*;

  logic          push, pop;
  char_desc_t    push_desc, head_desc;
  queue_status_t q_status;
  colors_t       colors;
  logic [15:0]   fore_q, back_q;

  // color registers, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fore_q <= ForeColorRst;
      back_q <= BackColorRst;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == RegForeColor) begin
        fore_q <= cfg_i.data;
      end else if (cfg_i.index == RegBackColor) begin
        back_q <= cfg_i.data;
      end
    end
  end

  assign colors.fore = fore_q;
  assign colors.back = back_q;

  // front end
  gws_front #(
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_front (
    .char_i      (char_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_desc_o (push_desc)
  );

  // descriptor queue
  gws_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .head_desc_o (head_desc),
    .status_o    (q_status)
  );

  // back end
  gws_back #(
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .colors_i    (colors),
    .head_desc_i (head_desc),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .word_o      (word_o)
  );

  // the final word of a character is always a pixel
  a_last_is_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_o.valid && word_o.last |-> word_o.is_data)
    else $error("last flag on a command word");

  // a transfer in leaves at least one queued character
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_i.valid && char_i.ready |=> q_status.count != '0)
    else $error("accepted character missing from queue");

  // never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // foreground register takes the written value
  a_fore_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid && cfg_i.ready && cfg_i.index == RegForeColor |=> fore_q == $past(cfg_i.data))
    else $error("foreground color write lost");

endmodule

@@ tb/sv/testbench.sv @@
// testbench for glyph_window_streamer_core: draws characters and checks every controller word
// depends on gws_pkg and the gws_if interfaces; predicts window commands and glyph pixels
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gws_pkg::*;

  localparam int unsigned GlyphW     = GlyphWidthDef;
  localparam int unsigned GlyphH     = GlyphHeightDef;
  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned TailCycles = 60;
  localparam int unsigned HoldCycles = 400;

  // indexes past the two color registers, writes there must be dropped
  localparam logic [CfgIdxW-1:0] RegSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 2'd3;

  // printable ascii 32..126, one 40-bit entry per code, column 0 in the top byte
  localparam logic [39:0] FontRom [95] = '{
    40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
    40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_00_03_00_00,
    40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
    40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h62_51_49_49_46, 40'h22_41_49_49_36,
    40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
    40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
    40'h32_49_79_41_3E, 40'h7C_12_11_12_7C, 40'h41_7F_49_49_36, 40'h3E_41_41_41_22,
    40'h41_7F_41_41_3E, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_41_49_7A,
    40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
    40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
    40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h26_49_49_49_32,
    40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
    40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7F_41_41_00,
    40'h02_04_08_10_20, 40'h00_41_41_7F_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
    40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_20,
    40'h38_44_44_48_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h08_54_54_54_3C,
    40'h7F_08_04_04_78, 40'h00_48_7D_40_00, 40'h20_40_44_3D_00, 40'h7F_10_28_44_00,
    40'h00_41_7F_40_00, 40'h7C_04_78_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
    40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
    40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
    40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h00_08_36_41_00,
    40'h00_00_7F_00_00, 40'h00_41_36_08_00, 40'h10_08_08_10_08
  };

  // one word of the controller stream
  typedef struct packed {
    logic        is_data;
    logic [15:0] out_word;
    logic        bad_code;
    logic        last;
  } ctrl_word_t;

  logic clk;
  logic rst_n;

  gws_char_if char_if ();
  gws_word_if word_if ();
  gws_cfg_if  cfg_if ();

  glyph_window_streamer_core #(
    .GLYPH_WIDTH (GlyphW),
    .GLYPH_HEIGHT(GlyphH)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .char_i(char_if.sink),
    .word_o(word_if.source),
    .cfg_i (cfg_if.sink)
  );

  // color registers as the block should hold them
  logic [15:0] fore_reg;
  logic [15:0] back_reg;

  ctrl_word_t  pending_words_q[$];
  int unsigned n_chars;
  int unsigned n_bad_chars;
  int unsigned n_words;
  int unsigned n_color_sets;
  int unsigned n_errors;
  int unsigned cycle_cnt;

  // idling controls shared by the sender, the receiver and the tests
  bit          tx_gaps;
  bit          rx_stalls;
  int unsigned hold_req;

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3);
  endfunction

  // positions cluster near both ends so the window end wraps often
  function automatic logic [15:0] rand_pos();
    case ($urandom_range(5))
      0: return 16'($urandom_range(15));
      1: return 16'hFFFF - 16'($urandom_range(15));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // mostly printable codes, some outside the font
  function automatic logic [6:0] rand_code();
    if ($urandom_range(9) == 0) begin
      if ($urandom_range(7) == 0) return 7'd127;
      return 7'($urandom_range(31));
    end
    return 7'($urandom_range(126, 32));
  endfunction

  function automatic void push_word(logic is_data, logic [15:0] w, logic bad, logic last);
    ctrl_word_t cw;
    cw.is_data  = is_data;
    cw.out_word = w;
    cw.bad_code = bad;
    cw.last     = last;
    pending_words_q.push_back(cw);
  endfunction

  // window commands, coordinate bytes, then the glyph pixels row by row
  function automatic void predict_char_stream(logic [15:0] x, logic [15:0] y, logic [6:0] code);
    logic        bad;
    logic [15:0] x_end;
    logic [15:0] y_end;
    logic [39:0] glyph;
    logic [7:0]  col_bits;
    int unsigned k;
    int unsigned r;
    int unsigned c;
    bad   = (code < FirstCode) || (code > LastCode);
    glyph = bad ? 40'h0 : FontRom[int'(code) - int'(FirstCode)];
    x_end = x + 16'(GlyphW - 1);
    y_end = y + 16'(GlyphH - 1);
    push_word(1'b0, CmdColWin, bad, 1'b0);
    push_word(1'b1, {8'h00, x[15:8]}, bad, 1'b0);
    push_word(1'b1, {8'h00, x[7:0]}, bad, 1'b0);
    push_word(1'b1, {8'h00, x_end[15:8]}, bad, 1'b0);
    push_word(1'b1, {8'h00, x_end[7:0]}, bad, 1'b0);
    push_word(1'b0, CmdRowWin, bad, 1'b0);
    push_word(1'b1, {8'h00, y[15:8]}, bad, 1'b0);
    push_word(1'b1, {8'h00, y[7:0]}, bad, 1'b0);
    push_word(1'b1, {8'h00, y_end[15:8]}, bad, 1'b0);
    push_word(1'b1, {8'h00, y_end[7:0]}, bad, 1'b0);
    push_word(1'b0, CmdMemWr, bad, 1'b0);
    k = 0;
    for (r = 0; r < GlyphH; r++) begin
      for (c = 0; c < GlyphW; c++) begin
        // columns past the table read as blank
        col_bits = (c < RomCols) ? glyph[39 - 8*c -: 8] : 8'h00;
        k++;
        push_word(1'b1, col_bits[r % 8] ? fore_reg : back_reg, bad, k == GlyphW * GlyphH);
      end
    end
  endfunction

  // offer one character, valid stays high for a following one
  task automatic send_char(logic [15:0] x, logic [15:0] y, logic [6:0] code);
    int unsigned gap;
    gap = 0;
    if (tx_gaps && $urandom_range(1) == 1) gap = gap_len();
    if (gap != 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_if.valid     <= 1'b1;
    char_if.pos_x     <= x;
    char_if.pos_y     <= y;
    char_if.char_code <= code;
    do @(posedge clk); while (!char_if.ready);
    predict_char_stream(x, y, code);
    n_chars++;
    if ((code < FirstCode) || (code > LastCode)) n_bad_chars++;
  endtask

  // stop offering and wait for every predicted word
  task automatic drain();
    if (char_if.valid) char_if.valid <= 1'b0;
    while (pending_words_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      RegForeColor: fore_reg = value;
      RegBackColor: back_reg = value;
      default: ;
    endcase
  endtask

  // set both colors while idle, optionally with dropped writes to the spare indexes
  task automatic apply_colors(logic [15:0] fore, logic [15:0] back, bit with_spare);
    drain();
    write_reg(RegForeColor, fore);
    if (with_spare) begin
      write_reg(RegSpareLo, 16'($urandom_range(65535)));
      write_reg(RegSpareHi, 16'($urandom_range(65535)));
    end
    write_reg(RegBackColor, back);
    cfg_if.valid <= 1'b0;
    n_color_sets++;
  endtask

  task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      n_errors++;
    end
  endtask

  // check each transferred word against the oldest prediction
  always @(posedge clk) begin
    ctrl_word_t want;
    if (rst_n && word_if.valid && word_if.ready) begin
      if (pending_words_q.size() == 0) begin
        $error("unexpected word: is_data %b out_word %h", word_if.is_data, word_if.out_word);
        n_errors++;
      end else begin
        want = pending_words_q.pop_front();
        cmp_field("is_data", 16'(want.is_data), 16'(word_if.is_data));
        cmp_field("out_word", want.out_word, word_if.out_word);
        cmp_field("bad_code", 16'(want.bad_code), 16'(word_if.bad_code));
        cmp_field("last", 16'(want.last), 16'(word_if.last));
        n_words++;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when a test asks for one
  initial begin
    word_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_req != 0) begin
        word_if.ready <= 1'b0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
      end else if (!rx_stalls || $urandom_range(3) != 0) begin
        word_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        word_if.ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // reset colors, extreme positions, window wrap, codes outside the font
  task automatic test_reset_colors();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b1;
    send_char(16'h0000, 16'h0000, 7'd65);
    send_char(16'hFFFF, 16'hFFFF, 7'd126);
    send_char(16'hFFFC, 16'hFFFA, 7'd32);
    send_char(16'hFFFB, 16'hFFF9, 7'd33);
    send_char(16'h00FF, 16'h00FC, 7'd56);
    send_char(16'h1234, 16'hABCD, 7'd0);
    send_char(16'h8000, 16'h7FFF, 7'd31);
    send_char(16'h5555, 16'hAAAA, 7'd127);
    send_char(16'hAAAA, 16'h5555, 7'd64);
    drain();
  endtask

  // color registers at their extremes, equal colors, dropped spare writes
  task automatic test_color_regs();
    apply_colors(16'h0000, 16'hFFFF, 1'b0);
    send_char(16'h0123, 16'h8765, 7'd77);
    send_char(16'hFFFF, 16'h0000, 7'd5);
    apply_colors(16'hF800, 16'h07E0, 1'b1);
    send_char(16'h00F0, 16'hFF00, 7'd72);
    send_char(16'h0F0F, 16'hF0F0, 7'd127);
    apply_colors(16'hA5A5, 16'hA5A5, 1'b1);
    send_char(16'h3C3C, 16'hC3C3, 7'd35);
    drain();
  endtask

  // every code once, random places and colors
  task automatic test_code_sweep();
    int unsigned code;
    apply_colors(16'($urandom_range(65535)), 16'($urandom_range(65535)), 1'b0);
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    for (code = 0; code < 128; code++) send_char(rand_pos(), rand_pos(), 7'(code));
    drain();
  endtask

  // long receiver hold-off while characters keep coming back to back
  task automatic test_output_hold();
    int unsigned i;
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    hold_req  = HoldCycles;
    for (i = 0; i < 10; i++) send_char(rand_pos(), rand_pos(), rand_code());
    drain();
  endtask

  // phases of random characters, each with its own colors and idling mix
  task automatic test_random_phases();
    int unsigned ph;
    int unsigned i;
    logic [15:0] fore;
    logic [15:0] back;
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin fore = 16'hFFFF; back = 16'h0000; end
        1: begin fore = 16'h0000; back = 16'h0000; end
        2: begin fore = 16'hFFFF; back = 16'hFFFF; end
        default: begin
          fore = 16'($urandom_range(65535));
          back = 16'($urandom_range(65535));
        end
      endcase
      apply_colors(fore, back, $urandom_range(1) == 1);
      tx_gaps   = ph[0];
      rx_stalls = ph[1];
      for (i = 0; i < 35; i++) send_char(rand_pos(), rand_pos(), rand_code());
    end
    drain();
  endtask

  // test sequence
  initial begin
    rst_n             = 1'b0;
    char_if.valid     = 1'b0;
    char_if.pos_x     = '0;
    char_if.pos_y     = '0;
    char_if.char_code = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    fore_reg          = ForeColorRst;
    back_reg          = BackColorRst;
    tx_gaps           = 1'b0;
    rx_stalls         = 1'b0;
    hold_req          = 0;
    n_chars           = 0;
    n_bad_chars       = 0;
    n_words           = 0;
    n_color_sets      = 0;
    n_errors          = 0;
    cycle_cnt         = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_colors();
    test_color_regs();
    test_code_sweep();
    test_output_hold();
    test_random_phases();

    repeat (TailCycles) @(posedge clk);
    $display("drew %0d characters (%0d outside the font) under %0d color settings",
             n_chars, n_bad_chars, n_color_sets + 1);
    $display("checked %0d controller words in %0d cycles", n_words, cycle_cnt);
    if (n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ glyph_window_streamer_core.f @@
rtl/core/gws_pkg.sv
rtl/core/gws_if.sv
rtl/core/gws_front.sv
rtl/core/gws_queue.sv
rtl/core/gws_back.sv
rtl/core/glyph_window_streamer_core.sv
tb/sv/testbench.sv
